/* hw/rtl/tqa_pkg.sv */
// Tree ancestor query package: payload widths, item and result types, opcodes, states.
// No dependencies; the interface, walker, top-level and testbench files import it.
`timescale 1ns / 1ps
package tqa_pkg;

  localparam int NODES_DEF = 16;
  localparam int NODE_W    = 8;
  localparam int ROW_W     = 16;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef struct packed {
    op_t               operation;
    logic [NODE_W-1:0] row_index;
    logic [ROW_W-1:0]  row_bits;
    logic [NODE_W-1:0] start_node;
    logic [NODE_W-1:0] target_node;
  } item_t;

  typedef struct packed {
    logic path_found;
    logic out_of_range;
    logic step_limit_hit;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_FLUSH,
    ST_WALK,
    ST_ANSWER
  } state_t;

endpackage

/* hw/rtl/tqa_ifs.sv */
// Valid/ready channel interfaces for query items and results.
// Depends on tqa_pkg for payload widths.
`timescale 1ns / 1ps
interface tqa_in_if;
  import tqa_pkg::*;

  logic              valid;
  logic              ready;
  logic              operation;
  logic [NODE_W-1:0] row_index;
  logic [ROW_W-1:0]  row_bits;
  logic [NODE_W-1:0] start_node;
  logic [NODE_W-1:0] target_node;

  modport source (output valid, operation, row_index, row_bits, start_node, target_node,
                  input ready);
  modport sink (input valid, operation, row_index, row_bits, start_node, target_node,
                output ready);
endinterface

interface tqa_out_if;
  logic valid;
  logic ready;
  logic path_found;
  logic out_of_range;
  logic step_limit_hit;

  modport source (output valid, path_found, out_of_range, step_limit_hit, input ready);
  modport sink (input valid, path_found, out_of_range, step_limit_hit, output ready);
endinterface

/* hw/rtl/tqa_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module tqa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/tqa_walker.sv */
// Sequencer for row-write sweeps and parent walks over the column-major edge RAM.
// Depends on tqa_pkg; drives one tqa_ram instance held by the top level.
`timescale 1ns / 1ps
module tqa_walker #(
  parameter int NODES = tqa_pkg::NODES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     item_take,
  input  tqa_pkg::item_t           item,
  output logic                     idle,
  output logic                     res_valid,
  output tqa_pkg::result_t         res,
  input  logic                     res_take,
  output logic                     ram_we,
  output logic [$clog2(NODES)-1:0] ram_waddr,
  output logic [NODES-1:0]         ram_wdata,
  output logic [$clog2(NODES)-1:0] ram_raddr,
  input  logic [NODES-1:0]         ram_rdata
);
  import tqa_pkg::*;

  localparam int IDXW = $clog2(NODES);

  state_t            state_r, state_nxt;
  logic [IDXW-1:0]   cnt_r, cnt_nxt;
  logic [IDXW-1:0]   ri_r, ri_nxt;
  logic [NODES-1:0]  row_vec_r, row_vec_nxt;
  logic [IDXW-1:0]   u_r, u_nxt;
  logic [IDXW-1:0]   cur_r, cur_nxt;
  logic [IDXW-1:0]   climbs_r, climbs_nxt;
  result_t           res_r, res_nxt;
  logic              loaded_r, loaded_nxt;

  logic [NODES-1:0]  row_vec;
  logic [NODES-1:0]  col_q;
  logic [IDXW-1:0]   parent;
  logic [IDXW-1:0]   wcol;
  logic              hit, none, last, done, row_ok, node_oor;
  result_t           walk_res;

  for (genvar j = 0; j < NODES; j++) begin : g_row
    if (j < ROW_W) begin : g_lo
      assign row_vec[j] = item.row_bits[j];
    end else begin : g_hi
      assign row_vec[j] = 1'b0;
    end
  end

  assign col_q    = loaded_r ? ram_rdata : '0;
  assign row_ok   = item.row_index < NODE_W'(NODES);
  assign node_oor = (item.start_node >= NODE_W'(NODES)) ||
                    (item.target_node >= NODE_W'(NODES));
  assign hit      = (cur_r == u_r) || col_q[u_r];
  assign none     = ~|col_q;
  assign last     = climbs_r == IDXW'(NODES - 1);
  assign done     = hit || none || last;
  assign wcol     = (state_r == ST_FLUSH) ? cnt_r : cnt_r - IDXW'(1);

  always_comb begin
    walk_res                = '0;
    walk_res.path_found     = hit;
    walk_res.step_limit_hit = !hit && !none && last;
  end

  always_comb begin
    parent = '0;
    for (int i = NODES - 1; i >= 0; i--) begin
      if (col_q[i]) begin
        parent = IDXW'(i);
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (item_take) begin
          if (item.operation == OP_WRITE) begin
            state_nxt = row_ok ? ST_WRITE : ST_IDLE;
          end else begin
            state_nxt = node_oor ? ST_ANSWER : ST_WALK;
          end
        end
      end
      ST_WRITE: begin
        if (cnt_r == IDXW'(NODES - 1)) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: state_nxt = ST_IDLE;
      ST_WALK: begin
        if (done) begin
          state_nxt = res_take ? ST_IDLE : ST_ANSWER;
        end
      end
      ST_ANSWER: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    cnt_nxt     = cnt_r;
    ri_nxt      = ri_r;
    row_vec_nxt = row_vec_r;
    u_nxt       = u_r;
    cur_nxt     = cur_r;
    climbs_nxt  = climbs_r;
    res_nxt     = res_r;
    loaded_nxt  = loaded_r;
    idle        = 1'b0;
    res_valid   = 1'b0;
    res         = res_r;
    ram_we      = 1'b0;
    ram_waddr   = wcol;
    ram_wdata   = col_q;
    ram_wdata[ri_r] = row_vec_r[wcol];
    ram_raddr   = cur_r;
    case (state_r)
      ST_IDLE: begin
        idle      = 1'b1;
        ram_raddr = item.target_node[IDXW-1:0];
        if (item_take) begin
          cnt_nxt     = '0;
          ri_nxt      = item.row_index[IDXW-1:0];
          row_vec_nxt = row_vec;
          u_nxt       = item.start_node[IDXW-1:0];
          cur_nxt     = item.target_node[IDXW-1:0];
          climbs_nxt  = '0;
          res_nxt     = '0;
          res_nxt.out_of_range = 1'b1;
        end
      end
      ST_WRITE: begin
        ram_raddr = cnt_r;
        ram_we    = cnt_r != '0;
        if (cnt_r != IDXW'(NODES - 1)) begin
          cnt_nxt = cnt_r + IDXW'(1);
        end
      end
      ST_FLUSH: begin
        ram_we     = 1'b1;
        loaded_nxt = 1'b1;
      end
      ST_WALK: begin
        if (done) begin
          res_nxt   = walk_res;
          res       = walk_res;
          res_valid = 1'b1;
        end else begin
          cur_nxt    = parent;
          climbs_nxt = climbs_r + IDXW'(1);
          ram_raddr  = parent;
        end
      end
      ST_ANSWER: res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      loaded_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      loaded_r <= loaded_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    ri_r      <= ri_nxt;
    row_vec_r <= row_vec_nxt;
    u_r       <= u_nxt;
    cur_r     <= cur_nxt;
    climbs_r  <= climbs_nxt;
    res_r     <= res_nxt;
  end

endmodule

/* hw/rtl/tree_ancestor_query_unit.sv */
// Tree ancestor query unit: edge RAM, walk sequencer and result output register.
// Depends on tqa_pkg, tqa_ifs, tqa_ram and tqa_walker.
//
//   Port     Dir  Transaction
//   in_ch    in   row write (operation 0) or ancestor query (operation 1)
//   out_ch   out  one result per query: path_found, out_of_range, step_limit_hit
//
// An in-range row write sweeps all NODES columns of the column-major edge RAM.
// A query climbs one parent link per cycle through the RAM read port; an out-of-range
// query skips the walk and answers from the ANSWER state. Reset is synchronous; the RAM
// needs no clearing pass, a loaded flag masks it until the first in-range row write.
// A stalled result sits in the output register while the next transaction is taken.
`timescale 1ns / 1ps
module tree_ancestor_query_unit #(
  parameter int NODES = tqa_pkg::NODES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tqa_in_if.sink     in_ch,
  tqa_out_if.source  out_ch
);
  import tqa_pkg::*;

  localparam int IDXW = $clog2(NODES);

  item_t            item;
  result_t          res;
  result_t          out_res_r, out_res_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             idle, res_valid, res_take, in_take;
  logic             ram_we;
  logic [IDXW-1:0]  ram_waddr, ram_raddr;
  logic [NODES-1:0] ram_wdata, ram_rdata;

  assign item.operation   = op_t'(in_ch.operation);
  assign item.row_index   = in_ch.row_index;
  assign item.row_bits    = in_ch.row_bits;
  assign item.start_node  = in_ch.start_node;
  assign item.target_node = in_ch.target_node;

  assign in_ch.ready = idle;
  assign in_take     = in_ch.valid && idle;
  assign res_take    = !out_valid_r || out_ch.ready;

  tqa_ram #(
    .WIDTH (NODES),
    .DEPTH (NODES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tqa_walker #(
    .NODES (NODES)
  ) u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_take (in_take),
    .item      (item),
    .idle      (idle),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_res_nxt   = out_res_r;
    if (res_valid && res_take) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.path_found     = out_res_r.path_found;
  assign out_ch.out_of_range   = out_res_r.out_of_range;
  assign out_ch.step_limit_hit = out_res_r.step_limit_hit;

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> $countones({out_ch.path_found, out_ch.out_of_range,
                                 out_ch.step_limit_hit}) <= 1)
    else $error("result carries more than one flag");

  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && item.operation == OP_WRITE && item.row_index < NODE_W'(NODES)
    |=> !in_ch.ready)
    else $error("in-range row write did not start a sweep");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && item.operation == OP_QUERY |=> !in_ch.ready)
    else $error("query accepted without walking");

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(!in_ch.ready))
    else $error("result loaded while sequencer idle");

endmodule

/* dv/tree_ancestor_query_unit_test.sv */
// Self-checking testbench for tree_ancestor_query_unit: row writes and ancestor queries.
// Predicts each answer with a scoreboard class. Depends on tqa_pkg, tqa_ifs and the RTL.
`timescale 1ns / 1ps

class ancestry_scoreboard;
  logic [tqa_pkg::ROW_W-1:0] edges [tqa_pkg::NODES_DEF];
  tqa_pkg::result_t          pending_answers [$];
  int                        errors;

  function new();
    foreach (edges[i]) edges[i] = '0;
    errors = 0;
  endfunction

  function tqa_pkg::result_t climb_answer(int u, int v);
    tqa_pkg::result_t r;
    int               cur;
    int               par;
    int               climbs;
    int               row;
    bit               has_parent;
    r = '0;
    if (u >= tqa_pkg::NODES_DEF || v >= tqa_pkg::NODES_DEF) begin
      r.out_of_range = 1'b1;
      return r;
    end
    cur = v;
    for (climbs = 0; climbs < tqa_pkg::NODES_DEF; climbs++) begin
      if (cur == u || edges[u][cur]) begin
        r.path_found = 1'b1;
        return r;
      end
      has_parent = 1'b0;
      par        = 0;
      for (row = tqa_pkg::NODES_DEF - 1; row >= 0; row--) begin
        if (edges[row][cur]) begin
          par        = row;
          has_parent = 1'b1;
        end
      end
      if (!has_parent) return r;
      cur = par;
    end
    r.step_limit_hit = 1'b1;
    return r;
  endfunction

  function void log_request(tqa_pkg::item_t it);
    if (it.operation == tqa_pkg::OP_WRITE) begin
      if (it.row_index < tqa_pkg::NODES_DEF) edges[it.row_index] = it.row_bits;
    end else begin
      pending_answers.push_back(climb_answer(int'(it.start_node), int'(it.target_node)));
    end
  endfunction

  task report(string msg);
    if (errors < 40) $display("mismatch: %s", msg);
    errors++;
  endtask

  task check_answer(tqa_pkg::result_t got);
    tqa_pkg::result_t want;
    if (pending_answers.size() == 0) begin
      report($sformatf("result %b with no query outstanding", got));
      return;
    end
    want = pending_answers.pop_front();
    if (got.path_found !== want.path_found)
      report($sformatf("path_found %b, want %b", got.path_found, want.path_found));
    if (got.out_of_range !== want.out_of_range)
      report($sformatf("out_of_range %b, want %b", got.out_of_range, want.out_of_range));
    if (got.step_limit_hit !== want.step_limit_hit)
      report($sformatf("step_limit_hit %b, want %b", got.step_limit_hit, want.step_limit_hit));
  endtask
endclass

module tree_ancestor_query_unit_test;
  import tqa_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE      = 40;

  logic clk;
  logic rst_n;
  int   idle_pct;
  int   stall_pct;
  int   sent;
  int   cycles;

  ancestry_scoreboard sb;

  tqa_in_if  in_ch ();
  tqa_out_if out_ch ();

  tree_ancestor_query_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.path_found     = out_ch.path_found;
      got.out_of_range   = out_ch.out_of_range;
      got.step_limit_hit = out_ch.step_limit_hit;
      sb.check_answer(got);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic item_t write_item(int row, logic [ROW_W-1:0] bits);
    item_t it;
    it.operation   = OP_WRITE;
    it.row_index   = NODE_W'(row);
    it.row_bits    = bits;
    it.start_node  = NODE_W'($urandom);
    it.target_node = NODE_W'($urandom);
    return it;
  endfunction

  function automatic item_t query_item(int u, int v);
    item_t it;
    it.operation   = OP_QUERY;
    it.row_index   = NODE_W'($urandom);
    it.row_bits    = ROW_W'($urandom);
    it.start_node  = NODE_W'(u);
    it.target_node = NODE_W'(v);
    return it;
  endfunction

  task automatic send(input item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= it.operation;
    in_ch.row_index   <= it.row_index;
    in_ch.row_bits    <= it.row_bits;
    in_ch.start_node  <= it.start_node;
    in_ch.target_node <= it.target_node;
    do @(posedge clk); while (!in_ch.ready);
    sb.log_request(it);
    if (!(it.operation == OP_WRITE && it.row_index >= NODES_DEF)) sent++;
  endtask

  // hold the input idle until every outstanding answer is back
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending_answers.size() != 0);
  endtask

  task automatic directed_items();
    send(query_item(0, 0));
    send(query_item(3, 5));
    send(write_item(255, 16'hFFFF));
    send(write_item(NODES_DEF, 16'hFFFF));
    send(query_item(2, 7));
    send(write_item(0, 16'hFFFF));
    send(query_item(4, 9));
    send(write_item(0, 16'h0002));
    send(write_item(1, 16'h0004));
    send(write_item(2, 16'h0008));
    send(write_item(3, 16'h0010));
    send(query_item(0, 4));
    send(query_item(4, 0));
    send(query_item(15, 15));
    send(query_item(NODES_DEF, 0));
    send(query_item(0, 255));
    send(query_item(255, 255));
    send(write_item(4, 16'h0001));
    send(query_item(9, 2));
    send(query_item(3, 1));
    send(write_item(15, 16'h8000));
    send(query_item(14, 15));
  endtask

  task automatic tree_sequence();
    int               order [NODES_DEF];
    logic [ROW_W-1:0] rows [NODES_DEF];
    int               i;
    int               j;
    int               tmp;
    int               pick;
    int               u;
    for (i = 0; i < NODES_DEF; i++) begin
      order[i] = i;
      rows[i]  = '0;
    end
    for (i = NODES_DEF - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (i = 1; i < NODES_DEF; i++) begin
      if ($urandom_range(0, 9) != 0) begin
        pick = $urandom_range(0, 1) ? i - 1 : $urandom_range(0, i - 1);
        rows[order[pick]][order[i]] = 1'b1;
      end
    end
    // close a loop back to the root now and then
    if ($urandom_range(0, 3) == 0) rows[order[NODES_DEF-1]][order[0]] = 1'b1;
    for (i = 0; i < NODES_DEF; i++) send(write_item(i, rows[i]));
    repeat ($urandom_range(4, 12)) begin
      u = ($urandom_range(0, 2) == 0) ? order[0] : $urandom_range(0, NODES_DEF - 1);
      send(query_item(u, $urandom_range(0, NODES_DEF - 1)));
    end
  endtask

  task automatic noise_sequence();
    int row;
    repeat ($urandom_range(1, 6)) begin
      row = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                        : $urandom_range(0, NODES_DEF - 1);
      send(write_item(row, ROW_W'($urandom)));
    end
    repeat ($urandom_range(1, 4))
      send(query_item($urandom_range(0, NODES_DEF - 1), $urandom_range(0, NODES_DEF - 1)));
  endtask

  task automatic random_items(int count);
    int goal;
    int mode;
    goal = sent + count;
    while (sent < goal) begin
      mode = $urandom_range(0, 99);
      if (mode < 70) tree_sequence();
      else if (mode < 85) noise_sequence();
      else send(query_item($urandom_range(0, 255), $urandom_range(0, 255)));
    end
  endtask

  initial begin
    sb        = new();
    sent      = 0;
    idle_pct  = 7;
    stall_pct = 56;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.operation   <= OP_WRITE;
    in_ch.row_index   <= '0;
    in_ch.row_bits    <= '0;
    in_ch.start_node  <= '0;
    in_ch.target_node <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    directed_items();
    random_items(300);
    drain();

    idle_pct  = 56;
    stall_pct = 7;
    random_items(350);
    drain();

    idle_pct  = 0;
    stall_pct = 0;
    random_items(350);
    drain();
    repeat (SETTLE) @(posedge clk);

    if (sb.errors == 0 && sb.pending_answers.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
